@@ rtl/oal_pkg.sv @@
// Shared types and constants for the ordered array list engine.
`default_nettype none

package oal_pkg;

    localparam int FUNC_W = 4;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int CAP_W  = 5;

    localparam logic [FUNC_W-1:0] FN_INSERT       = 4'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT_FRONT = 4'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT_BACK  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE       = 4'd3;
    localparam logic [FUNC_W-1:0] FN_REMOVE_FRONT = 4'd4;
    localparam logic [FUNC_W-1:0] FN_REMOVE_BACK  = 4'd5;
    localparam logic [FUNC_W-1:0] FN_REPLACE      = 4'd6;
    localparam logic [FUNC_W-1:0] FN_SELECT       = 4'd7;
    localparam logic [FUNC_W-1:0] FN_SEARCH       = 4'd8;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [FUNC_W-1:0] func_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_req;
        logic commit;
        logic match_capture;
        logic search_commit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic req_is_search;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ rtl/oal_req_if.sv @@
// Request channel interface: operation code, position and value.
`default_nettype none

interface oal_req_if;
    logic                      valid;
    logic                      ready;
    logic [oal_pkg::FUNC_W-1:0] func;
    logic [oal_pkg::POS_W-1:0]  position;
    logic [oal_pkg::VAL_W-1:0]  value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink   (input valid, input func, input position, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/oal_rsp_if.sv @@
// Result channel interface: flag, read data, search position and list status.
`default_nettype none

interface oal_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic [oal_pkg::VAL_W-1:0]  read_value;
    logic [oal_pkg::POS_W-1:0]  found_position;
    logic [oal_pkg::POS_W-1:0]  entry_count;
    logic                      is_empty;
    logic                      is_full;

    modport source (output valid, output ok, output read_value, output found_position,
                    output entry_count, output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input read_value, input found_position,
                    input entry_count, input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

@@ rtl/oal_ctrl.sv @@
// Controller state machine: sequences accept, execute and search finish.
`default_nettype none

module oal_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire oal_pkg::sts_t sts,
    output oal_pkg::cmd_t      cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        req_ready         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.req_is_search)
                begin
                    cmd.match_capture = 1'b1;
                    state_next        = S_SRCH;
                end
                else if (sts.out_free)
                begin
                    // update list and load result in the same cycle
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SRCH:
            begin
                if (sts.out_free)
                begin
                    cmd.search_commit = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/oal_dp.sv @@
// Datapath: list cells, count, capacity register, search match vector, result register.
`default_nettype none

module oal_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [oal_pkg::CAP_W-1:0]    cfg_wdata,
    input  wire logic [oal_pkg::FUNC_W-1:0]   in_func,
    input  wire logic [oal_pkg::POS_W-1:0]    in_position,
    input  wire logic [oal_pkg::VAL_W-1:0]    in_value,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic                              out_ok,
    output logic [oal_pkg::VAL_W-1:0]         out_read_value,
    output logic [oal_pkg::POS_W-1:0]         out_found_position,
    output logic [oal_pkg::POS_W-1:0]         out_entry_count,
    output logic                              out_is_empty,
    output logic                              out_is_full,
    input  wire oal_pkg::cmd_t                cmd,
    output oal_pkg::sts_t                     sts
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > oal_pkg::POS_W) ? CW : oal_pkg::POS_W;
    localparam int IW = $clog2(DEPTH);

    // request registers
    oal_pkg::func_t        func_reg;
    logic [PW-1:0]         pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;

    logic [DATA_WIDTH-1:0] cells_reg [DEPTH];
    logic [DATA_WIDTH-1:0] cells_next [DEPTH];
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [oal_pkg::CAP_W-1:0] cap_reg;
    logic [DEPTH-1:0]      match_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  ok_reg;
    logic [oal_pkg::VAL_W-1:0] rd_reg;
    logic [oal_pkg::POS_W-1:0] found_reg;
    logic [oal_pkg::POS_W-1:0] cnt_out_reg;
    logic                  empty_reg;
    logic                  full_reg;

    logic [63:0]           in_value_ext;
    logic [PW-1:0]         cnt;
    logic [PW-1:0]         cap_ext;
    logic [PW-1:0]         cap_eff;
    logic                  full_now;
    logic                  is_ins;
    logic                  is_rem;
    logic [PW-1:0]         ipos;
    logic [PW-1:0]         rpos;
    logic                  ins_ok;
    logic                  rem_ok;
    logic                  rep_ok;
    logic                  sel_ok;
    logic [PW-1:0]         sel_pos;
    logic [DATA_WIDTH-1:0] sel_data;
    logic [63:0]           sel_data_ext;
    logic [PW-1:0]         cnt_after;
    logic                  ok_exec;
    logic                  found_any;
    logic [PW-1:0]         found_idx;

    assign in_value_ext = 64'(in_value);

    // operation decode
    always_comb
    begin
        cnt     = PW'(count_reg);
        cap_ext = PW'(cap_reg);
        cap_eff = (cap_ext > PW'(DEPTH)) ? PW'(DEPTH) : cap_ext;
        full_now = (cnt >= cap_eff);

        is_ins = (func_reg == oal_pkg::FN_INSERT) || (func_reg == oal_pkg::FN_INSERT_FRONT) ||
                 (func_reg == oal_pkg::FN_INSERT_BACK);
        is_rem = (func_reg == oal_pkg::FN_REMOVE) || (func_reg == oal_pkg::FN_REMOVE_FRONT) ||
                 (func_reg == oal_pkg::FN_REMOVE_BACK);

        if (func_reg == oal_pkg::FN_INSERT)
            ipos = pos_reg;
        else if (func_reg == oal_pkg::FN_INSERT_FRONT)
            ipos = '0;
        else
            ipos = cnt;

        if (func_reg == oal_pkg::FN_REMOVE)
            rpos = pos_reg;
        else if (func_reg == oal_pkg::FN_REMOVE_FRONT)
            rpos = '0;
        else
            rpos = cnt - PW'(1);

        ins_ok = is_ins && !full_now && (ipos <= cnt);
        rem_ok = is_rem && (cnt != '0) && (rpos < cnt);
        rep_ok = (func_reg == oal_pkg::FN_REPLACE) && (pos_reg < cnt);
        sel_ok = (func_reg == oal_pkg::FN_SELECT) && (cnt != '0);

        sel_pos      = (pos_reg >= cnt) ? (cnt - PW'(1)) : pos_reg;
        sel_data     = cells_reg[sel_pos[IW-1:0]];
        sel_data_ext = 64'(sel_data);

        if (ins_ok)
            cnt_after = cnt + PW'(1);
        else if (rem_ok)
            cnt_after = cnt - PW'(1);
        else
            cnt_after = cnt;

        ok_exec    = ins_ok || rem_ok || rep_ok || sel_ok;
        count_next = CW'(cnt_after);
    end

    // each cell takes its own value, a neighbor, or the request value
    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_cell
        localparam logic [PW-1:0] IDX = PW'(gi);
        logic [DATA_WIDTH-1:0] from_below;
        logic [DATA_WIDTH-1:0] from_above;

        if (gi == 0)
        begin : g_lo
            assign from_below = cells_reg[gi];
        end
        else
        begin : g_mid
            assign from_below = cells_reg[gi-1];
        end

        if (gi == DEPTH - 1)
        begin : g_hi
            assign from_above = cells_reg[gi];
        end
        else
        begin : g_top
            assign from_above = cells_reg[gi+1];
        end

        always_comb
        begin
            cells_next[gi] = cells_reg[gi];
            if (ins_ok)
            begin
                if (IDX > ipos)
                    cells_next[gi] = from_below;
                else if (IDX == ipos)
                    cells_next[gi] = val_reg;
            end
            else if (rem_ok)
            begin
                if (IDX >= rpos)
                    cells_next[gi] = from_above;
            end
            else if (rep_ok)
            begin
                if (IDX == pos_reg)
                    cells_next[gi] = val_reg;
            end
        end
    end

    // lowest matching cell wins
    always_comb
    begin
        found_any = |match_reg;
        found_idx = cnt;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match_reg[i])
                found_idx = PW'(i);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit || cmd.search_commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign sts.out_free      = !out_valid_reg || out_ready;
    assign sts.req_is_search = (func_reg == oal_pkg::FN_SEARCH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= oal_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (cmd.commit)
                count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg <= in_func;
            pos_reg  <= PW'(in_position);
            val_reg  <= in_value_ext[DATA_WIDTH-1:0];
        end
        if (cmd.commit)
        begin
            for (int i = 0; i < DEPTH; i++)
                cells_reg[i] <= cells_next[i];
            ok_reg      <= ok_exec;
            rd_reg      <= sel_ok ? sel_data_ext[oal_pkg::VAL_W-1:0] : '0;
            found_reg   <= '0;
            cnt_out_reg <= cnt_after[oal_pkg::POS_W-1:0];
            empty_reg   <= (cnt_after == '0);
            full_reg    <= (cnt_after >= cap_eff);
        end
        if (cmd.match_capture)
        begin
            for (int i = 0; i < DEPTH; i++)
                match_reg[i] <= (cells_reg[i] == val_reg) && (PW'(i) < cnt);
        end
        if (cmd.search_commit)
        begin
            ok_reg      <= found_any;
            rd_reg      <= '0;
            found_reg   <= found_idx[oal_pkg::POS_W-1:0];
            cnt_out_reg <= cnt[oal_pkg::POS_W-1:0];
            empty_reg   <= (cnt == '0);
            full_reg    <= full_now;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_ok             = ok_reg;
    assign out_read_value     = rd_reg;
    assign out_found_position = found_reg;
    assign out_entry_count    = cnt_out_reg;
    assign out_is_empty       = empty_reg;
    assign out_is_full        = full_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        PW'(count_reg) <= PW'(DEPTH))
        else $error("list count above depth");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(count_reg))
        else $error("list count changed without an executed operation");

    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.search_commit) |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken transaction");

    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.commit && cmd.search_commit))
        else $error("two result loads in one cycle");

endmodule

`default_nettype wire

@@ rtl/ordered_array_list_engine_unit.sv @@
// Ordered array list engine: usage
// Requests arrive on the req channel (valid/ready); a transaction carries func, position
// and value. Each request gives exactly one result transaction on the rsp channel with
// ok, read_value, found_position, entry_count, is_empty and is_full.
// Insert, remove, replace and select first register the request, then all list cells
// shift or load in parallel and the result register is loaded. Search also registers
// the request first, then the cells compare against the key in
// parallel into a match register, then a priority encoder picks the first hit.
// One request is in flight at a time, so a new request is accepted only once the last one
// has loaded its result. A finished result sits in the output register while the next
// request is accepted; if the receiver stalls, execution holds until that register is
// taken and the list is not touched meanwhile.
// Reset empties the list (count 0) and sets the capacity limit to 16. Write the capacity
// through cfg_we/cfg_wdata only while no request is outstanding.
`default_nettype none

module ordered_array_list_engine_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [oal_pkg::CAP_W-1:0] cfg_wdata,
    oal_req_if.sink                        req,
    oal_rsp_if.source                      rsp
);

    oal_pkg::cmd_t cmd;
    oal_pkg::sts_t sts;

    oal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    oal_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .in_func            (req.func),
        .in_position        (req.position),
        .in_value           (req.value),
        .out_ready          (rsp.ready),
        .out_valid          (rsp.valid),
        .out_ok             (rsp.ok),
        .out_read_value     (rsp.read_value),
        .out_found_position (rsp.found_position),
        .out_entry_count    (rsp.entry_count),
        .out_is_empty       (rsp.is_empty),
        .out_is_full        (rsp.is_full),
        .cmd                (cmd),
        .sts                (sts)
    );

endmodule

`default_nettype wire
